### rtl/core/ffsd_pkg.sv
package ffsd_pkg;

  // frame geometry default
  localparam int FRAME_LEN_DEF = 363;

  // field widths
  localparam int BYTE_W = 8;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W = BYTE_W * WORD_BYTES;
  localparam int LANE_W = $clog2(WORD_BYTES);
  localparam int VB_W = 4;
  localparam int ID_W = 16;
  localparam int OFS_W = 9;

  // id_offset reset value
  localparam logic [OFS_W-1:0] ID_OFFSET_RST = OFS_W'(2);

  // sync pattern
  localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h55;
  localparam logic [BYTE_W-1:0] TRL_BYTE0 = 8'h0D;
  localparam logic [BYTE_W-1:0] TRL_BYTE1 = 8'h0A;

endpackage

### rtl/core/ffsd_ram.sv
module ffsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 363
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fixed_frame_sync_deframer.sv
// sequence: after the byte that fills the window, S_HDR0 and S_HDR1 read the header bytes and
//   S_HDR2 checks sync; on a match S_ID0 to S_ID2 fetch the id, then frame bytes are read
//   through the registered store output and packed into words; input is taken only in
//   S_IDLE and stalls through each sync check and frame, and output stalls hold the stream
// reset: control state, held count, window start and previous id clear; id_offset returns
//   to 2; window store contents stay undefined until written
module fixed_frame_sync_deframer #(
  parameter int FRAME_LEN = ffsd_pkg::FRAME_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ffsd_pkg::BYTE_W-1:0]  data_byte_i,
  // id_offset register write
  input  logic                         cfg_we_i,
  input  logic [ffsd_pkg::OFS_W-1:0]   cfg_wdata_i,
  // frame word output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ffsd_pkg::WORD_W-1:0]  frame_word_o,
  output logic [ffsd_pkg::VB_W-1:0]    valid_bytes_o,
  output logic                         last_word_o,
  output logic [ffsd_pkg::ID_W-1:0]    frame_id_o,
  output logic                         id_gap_o,
  output logic [ffsd_pkg::ID_W-1:0]    lost_count_o
);

  localparam int ADDR_W = $clog2(FRAME_LEN);
  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam int BW = ffsd_pkg::BYTE_W;
  localparam int IW = ffsd_pkg::ID_W;
  localparam int LW = ffsd_pkg::LANE_W;
  localparam logic [CNT_W:0]   FL_X = (CNT_W + 1)'(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] END_POS = CNT_W'(FRAME_LEN);
  localparam logic [LW-1:0]    LANE_MAX = LW'(ffsd_pkg::WORD_BYTES - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HDR0   = 3'd1;
  localparam logic [2:0] S_HDR1   = 3'd2;
  localparam logic [2:0] S_HDR2   = 3'd3;
  localparam logic [2:0] S_ID0    = 3'd4;
  localparam logic [2:0] S_ID1    = 3'd5;
  localparam logic [2:0] S_ID2    = 3'd6;
  localparam logic [2:0] S_STREAM = 3'd7;

  // circular index of frame position pos; start and pos both stay below FRAME_LEN
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] start,
                                                  input logic [CNT_W-1:0]  pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(start) + (CNT_W + 1)'(pos);
    if (sum >= FL_X) begin
      sum = sum - FL_X;
    end
    return sum[ADDR_W-1:0];
  endfunction

  logic [2:0]                       state_q, state_d;
  logic [ADDR_W-1:0]                held_q, held_d;
  logic [ADDR_W-1:0]                start_q, start_d;
  logic [IW-1:0]                    prev_id_q, prev_id_d;
  logic [ffsd_pkg::OFS_W-1:0]       id_offset_q;
  logic                             out_valid_q, out_valid_d;
  logic                             pend_q, pend_d;
  logic [CNT_W-1:0]                 pos_q, pos_d;
  logic [CNT_W-1:0]                 pend_pos_q, pend_pos_d;

  // payload registers
  logic [BW-1:0]                    last_byte_q, prev_byte_q, hdr0_q, hdr0_d;
  logic [BW-1:0]                    id_lo_q, id_lo_d;
  logic [IW-1:0]                    id_q, id_d, lost_q, lost_d;
  logic                             gap_q, gap_d;
  logic [ffsd_pkg::WORD_W-1:0]      build_q, build_d;
  logic [ffsd_pkg::WORD_W-1:0]      out_word_q, out_word_d;
  logic [ffsd_pkg::VB_W-1:0]        out_vb_q, out_vb_d;
  logic                             out_last_q, out_last_d;
  logic [IW-1:0]                    out_id_q, out_id_d, out_lost_q, out_lost_d;
  logic                             out_gap_q, out_gap_d;

  // window store port
  logic                             ram_we, ram_re;
  logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
  logic [BW-1:0]                    ram_rdata;

  logic                             in_acc, out_free;
  logic [ffsd_pkg::OFS_W:0]         off_lo, off_hi;
  logic                             lo_in, hi_in;
  logic [CNT_W-1:0]                 lo_pos, hi_pos;
  logic [IW-1:0]                    id_c;
  logic                             gap_c;
  logic [LW-1:0]                    lane;
  logic                             pend_last, completes, consume, issue;
  logic [ffsd_pkg::WORD_W-1:0]      word_c;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // output register empties this cycle or already is empty
  assign out_free   = !out_valid_q || !out_stall_i;

  // id byte positions; a position past the frame end reads as zero
  assign off_lo = {1'b0, id_offset_q};
  assign off_hi = off_lo + 1'b1;
  assign lo_in  = int'(off_lo) < FRAME_LEN;
  assign hi_in  = int'(off_hi) < FRAME_LEN;
  assign lo_pos = lo_in ? CNT_W'(off_lo) : '0;
  assign hi_pos = hi_in ? CNT_W'(off_hi) : '0;

  assign id_c  = {(hi_in ? ram_rdata : {BW{1'b0}}), id_lo_q};
  assign gap_c = (prev_id_q != '0) && (id_c != prev_id_q + 1'b1);

  // byte-lane packing of the streamed frame
  assign lane      = pend_pos_q[LW-1:0];
  assign pend_last = (pend_pos_q == LAST_POS);
  assign completes = pend_q && ((lane == LANE_MAX) || pend_last);
  assign consume   = pend_q && (!completes || out_free);
  assign issue     = (state_q == S_STREAM) && (!pend_q || consume) && (pos_q != END_POS);

  always_comb begin
    word_c = build_q;
    word_c[lane * BW +: BW] = ram_rdata;
  end

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    start_d     = start_q;
    prev_id_d   = prev_id_q;
    hdr0_d      = hdr0_q;
    id_lo_d     = id_lo_q;
    id_d        = id_q;
    gap_d       = gap_q;
    lost_d      = lost_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    pend_pos_d  = pend_pos_q;
    build_d     = build_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    out_vb_d    = out_vb_q;
    out_last_d  = out_last_q;
    out_id_d    = out_id_q;
    out_gap_d   = out_gap_q;
    out_lost_d  = out_lost_q;
    ram_we      = 1'b0;
    ram_waddr   = wrap_addr(start_q, CNT_W'(held_q));
    ram_re      = 1'b0;
    ram_raddr   = wrap_addr(start_q, '0);

    unique case (state_q)
      S_IDLE: begin
        // store the byte; a full window goes to the sync check
        if (in_acc) begin
          ram_we = 1'b1;
          if (held_q == ADDR_W'(FRAME_LEN - 1)) begin
            state_d = S_HDR0;
          end else begin
            held_d = held_q + 1'b1;
          end
        end
      end
      S_HDR0: begin
        ram_re  = 1'b1;
        state_d = S_HDR1;
      end
      S_HDR1: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_addr(start_q, CNT_W'(1));
        hdr0_d    = ram_rdata;
        state_d   = S_HDR2;
      end
      S_HDR2: begin
        // trailer bytes are the two most recent stream bytes
        if (hdr0_q == ffsd_pkg::HDR_BYTE0 && ram_rdata == ffsd_pkg::HDR_BYTE1 &&
            prev_byte_q == ffsd_pkg::TRL_BYTE0 && last_byte_q == ffsd_pkg::TRL_BYTE1) begin
          state_d = S_ID0;
        end else begin
          // slide by one, window stays one short of full
          start_d = wrap_addr(start_q, CNT_W'(1));
          state_d = S_IDLE;
        end
      end
      S_ID0: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_addr(start_q, lo_pos);
        state_d   = S_ID1;
      end
      S_ID1: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_addr(start_q, hi_pos);
        id_lo_d   = lo_in ? ram_rdata : '0;
        state_d   = S_ID2;
      end
      S_ID2: begin
        id_d      = id_c;
        gap_d     = gap_c;
        lost_d    = gap_c ? (id_c - prev_id_q - 1'b1) : '0;
        prev_id_d = id_c;
        pos_d     = '0;
        pend_d    = 1'b0;
        build_d   = '0;
        state_d   = S_STREAM;
      end
      S_STREAM: begin
        // one read in flight; a finished word waits in the ram output until the
        // output register frees up
        if (consume) begin
          if (completes) begin
            out_valid_d = 1'b1;
            out_word_d  = word_c;
            out_vb_d    = ffsd_pkg::VB_W'(lane) + 1'b1;
            out_last_d  = pend_last;
            out_id_d    = id_q;
            out_gap_d   = gap_q;
            out_lost_d  = lost_q;
            build_d     = '0;
            if (pend_last) begin
              held_d  = '0;
              start_d = '0;
              state_d = S_IDLE;
            end
          end else begin
            build_d = word_c;
          end
        end
        if (issue) begin
          ram_re     = 1'b1;
          ram_raddr  = wrap_addr(start_q, pos_q);
          pos_d      = pos_q + 1'b1;
          pend_pos_d = pos_q;
          pend_d     = 1'b1;
        end else if (consume) begin
          pend_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      start_q     <= '0;
      prev_id_q   <= '0;
      id_offset_q <= ffsd_pkg::ID_OFFSET_RST;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      start_q     <= start_d;
      prev_id_q   <= prev_id_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      pos_q       <= pos_d;
      if (cfg_we_i) begin
        id_offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_byte_q <= data_byte_i;
      prev_byte_q <= last_byte_q;
    end
    hdr0_q     <= hdr0_d;
    id_lo_q    <= id_lo_d;
    id_q       <= id_d;
    gap_q      <= gap_d;
    lost_q     <= lost_d;
    pend_pos_q <= pend_pos_d;
    build_q    <= build_d;
    out_word_q <= out_word_d;
    out_vb_q   <= out_vb_d;
    out_last_q <= out_last_d;
    out_id_q   <= out_id_d;
    out_gap_q  <= out_gap_d;
    out_lost_q <= out_lost_d;
  end

  ffsd_ram #(
    .WIDTH (BW),
    .DEPTH (FRAME_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign frame_word_o  = out_word_q;
  assign valid_bytes_o = out_vb_q;
  assign last_word_o   = out_last_q;
  assign frame_id_o    = out_id_q;
  assign id_gap_o      = out_gap_q;
  assign lost_count_o  = out_lost_q;

  // window store is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !ram_re)
    else $error("window store written and read together");

  // an outstanding read only exists while streaming a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> (state_q == S_STREAM))
    else $error("pending read outside frame stream");

  // an issued read is pending on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) issue |=> pend_q)
    else $error("issued read lost");

  // circular pointers stay inside the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(start_q) < FRAME_LEN) && (int'(held_q) < FRAME_LEN) && (int'(pos_q) <= FRAME_LEN))
    else $error("window pointer out of range");

endmodule

### dv/ffsd_frame_checker.sv
`timescale 1ns / 1ps

module ffsd_frame_checker #(
  parameter int FRAME_LEN = ffsd_pkg::FRAME_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_valid_i,
  input  logic                         byte_stall_i,
  input  logic [ffsd_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                         cfg_we_i,
  input  logic [ffsd_pkg::OFS_W-1:0]   cfg_wdata_i,
  input  logic                         word_valid_i,
  input  logic                         word_stall_i,
  input  logic [ffsd_pkg::WORD_W-1:0]  frame_word_i,
  input  logic [ffsd_pkg::VB_W-1:0]    valid_bytes_i,
  input  logic                         last_word_i,
  input  logic [ffsd_pkg::ID_W-1:0]    frame_id_i,
  input  logic                         id_gap_i,
  input  logic [ffsd_pkg::ID_W-1:0]    lost_count_i,
  output int                           mismatches_o,
  output int                           words_due_o
);

  localparam int BYTE_W = ffsd_pkg::BYTE_W;
  localparam int WORD_BYTES = ffsd_pkg::WORD_BYTES;
  localparam int WORD_W = ffsd_pkg::WORD_W;
  localparam int VB_W = ffsd_pkg::VB_W;
  localparam int ID_W = ffsd_pkg::ID_W;
  localparam int OFS_W = ffsd_pkg::OFS_W;
  localparam int WORDS_PER_FRAME = (FRAME_LEN + WORD_BYTES - 1) / WORD_BYTES;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   nbytes;
    logic              last;
    logic [ID_W-1:0]   id;
    logic              gap;
    logic [ID_W-1:0]   lost;
  } frame_word_t;

  // shadow of the sliding window and the id tracking
  logic [BYTE_W-1:0] window_bytes [FRAME_LEN];
  int                held_bytes = 0;
  int                oldest_idx = 0;
  logic [ID_W-1:0]   last_id = '0;
  logic [OFS_W-1:0]  id_offset = ffsd_pkg::ID_OFFSET_RST;
  frame_word_t       frame_words_due [$];
  frame_word_t       want;
  int                mismatch_count = 0;
  int                words_due_count = 0;

  assign mismatches_o = mismatch_count;
  assign words_due_o  = words_due_count;

  function automatic logic [BYTE_W-1:0] window_byte(input int pos);
    if (pos >= FRAME_LEN) return '0;
    return window_bytes[(oldest_idx + pos) % FRAME_LEN];
  endfunction

  // one accepted byte: slide the window, on sync queue the whole frame
  function automatic void slide_and_sync(input logic [BYTE_W-1:0] rx_byte);
    logic [ID_W-1:0] id;
    logic            gap;
    logic [ID_W-1:0] lost;
    frame_word_t     fw;
    window_bytes[(oldest_idx + held_bytes) % FRAME_LEN] = rx_byte;
    held_bytes++;
    if (held_bytes < FRAME_LEN) return;
    if (!(window_byte(0) == ffsd_pkg::HDR_BYTE0 && window_byte(1) == ffsd_pkg::HDR_BYTE1 &&
          window_byte(FRAME_LEN - 2) == ffsd_pkg::TRL_BYTE0 &&
          window_byte(FRAME_LEN - 1) == ffsd_pkg::TRL_BYTE1)) begin
      oldest_idx = (oldest_idx + 1) % FRAME_LEN;
      held_bytes = FRAME_LEN - 1;
      return;
    end
    id = {window_byte(int'(id_offset) + 1), window_byte(int'(id_offset))};
    gap = (last_id != '0) && (id != last_id + 16'd1);
    lost = gap ? id - last_id - 16'd1 : '0;
    last_id = id;
    for (int w = 0; w < WORDS_PER_FRAME; w++) begin
      fw = '0;
      for (int b = 0; b < WORD_BYTES; b++) begin
        if (w * WORD_BYTES + b < FRAME_LEN) begin
          fw.word[b*BYTE_W +: BYTE_W] = window_byte(w * WORD_BYTES + b);
          fw.nbytes = fw.nbytes + 4'd1;
        end
      end
      fw.last = (w == WORDS_PER_FRAME - 1);
      fw.id = id;
      fw.gap = gap;
      fw.lost = lost;
      frame_words_due.push_back(fw);
    end
    held_bytes = 0;
    oldest_idx = 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] exp_val,
                                 input logic [WORD_W-1:0] got_val);
    mismatch_count++;
    $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_val, got_val);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_bytes = 0;
      oldest_idx = 0;
      last_id = '0;
      id_offset = ffsd_pkg::ID_OFFSET_RST;
      frame_words_due.delete();
    end else begin
      if (cfg_we_i) id_offset = cfg_wdata_i;
      if (byte_valid_i && !byte_stall_i) slide_and_sync(data_byte_i);
      if (word_valid_i && !word_stall_i) begin
        if (frame_words_due.size() == 0) begin
          report_mismatch("unexpected frame_word", '0, frame_word_i);
        end else begin
          want = frame_words_due.pop_front();
          if (frame_word_i !== want.word)
            report_mismatch("frame_word", want.word, frame_word_i);
          if (valid_bytes_i !== want.nbytes)
            report_mismatch("valid_bytes", WORD_W'(want.nbytes), WORD_W'(valid_bytes_i));
          if (last_word_i !== want.last)
            report_mismatch("last_word", WORD_W'(want.last), WORD_W'(last_word_i));
          if (frame_id_i !== want.id)
            report_mismatch("frame_id", WORD_W'(want.id), WORD_W'(frame_id_i));
          if (id_gap_i !== want.gap)
            report_mismatch("id_gap", WORD_W'(want.gap), WORD_W'(id_gap_i));
          if (lost_count_i !== want.lost)
            report_mismatch("lost_count", WORD_W'(want.lost), WORD_W'(lost_count_i));
        end
      end
    end
    words_due_count = frame_words_due.size();
  end

endmodule

### dv/fixed_frame_sync_deframer_test.sv
`timescale 1ns / 1ps

module fixed_frame_sync_deframer_test;

  localparam int FRAME_LEN = ffsd_pkg::FRAME_LEN_DEF;
  localparam int BYTE_W = ffsd_pkg::BYTE_W;
  localparam int WORD_W = ffsd_pkg::WORD_W;
  localparam int VB_W = ffsd_pkg::VB_W;
  localparam int ID_W = ffsd_pkg::ID_W;
  localparam int OFS_W = ffsd_pkg::OFS_W;
  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 7;
  // margin after the last expected word for a window check or a matched frame that is
  // still in flight
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES = 32;
  // watchdog limit for the whole run, in ns
  localparam longint TIMEOUT_NS = 10_000_000;
  localparam int RANDOM_PHASES = 4;
  localparam int SEGMENTS_PER_PHASE = 5;

  typedef enum logic [1:0] {
    FRAME_GOOD,
    FRAME_BAD_SYNC,
    FRAME_CUT
  } frame_kind_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // stream bytes that sit at the edges of the byte range or mimic sync
  localparam logic [BYTE_W-1:0] EDGE_BYTES [12] = '{
    8'h00, 8'hFF, ffsd_pkg::HDR_BYTE0, ffsd_pkg::HDR_BYTE1, ffsd_pkg::TRL_BYTE0,
    ffsd_pkg::TRL_BYTE1, ffsd_pkg::HDR_BYTE0, ffsd_pkg::HDR_BYTE1, 8'h01, 8'h80, 8'h7F, 8'hFE
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [BYTE_W-1:0]  data_byte_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [OFS_W-1:0]   cfg_wdata_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WORD_W-1:0]  frame_word_o;
  logic [VB_W-1:0]    valid_bytes_o;
  logic               last_word_o;
  logic [ID_W-1:0]    frame_id_o;
  logic               id_gap_o;
  logic [ID_W-1:0]    lost_count_o;

  int                 mismatches;
  int                 words_due;

  // sender burst bookkeeping and the offset the frame builder aims at
  int                 burst_left = 0;
  logic [OFS_W-1:0]   cur_offset = ffsd_pkg::ID_OFFSET_RST;
  logic [ID_W-1:0]    id_seq = '0;

  // receiver stall pattern state
  stall_mode_e        stall_mode = STALL_NONE;
  int                 stall_left = 0;

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  fixed_frame_sync_deframer #(
    .FRAME_LEN(FRAME_LEN)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_word_o (frame_word_o),
    .valid_bytes_o(valid_bytes_o),
    .last_word_o  (last_word_o),
    .frame_id_o   (frame_id_o),
    .id_gap_o     (id_gap_o),
    .lost_count_o (lost_count_o)
  );

  ffsd_frame_checker #(
    .FRAME_LEN(FRAME_LEN)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_i),
    .byte_stall_i (in_stall_o),
    .data_byte_i  (data_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .word_valid_i (out_valid_o),
    .word_stall_i (out_stall_i),
    .frame_word_i (frame_word_o),
    .valid_bytes_i(valid_bytes_o),
    .last_word_i  (last_word_o),
    .frame_id_i   (frame_id_o),
    .id_gap_i     (id_gap_o),
    .lost_count_i (lost_count_o),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  // receiver: every so often pick a new stall pattern and hold it for a while,
  // including stretches with no stall at all
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_COIN:     out_stall_i <= 1'($urandom_range(0, 1));
      STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall_i <= (stall_left % 3 == 0);
      default:        out_stall_i <= 1'b0;
    endcase
  end

  // one byte transaction; a new burst starts with a random gap, bursts are
  // mostly short but now and then span a whole frame with no idling
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 400 : 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // random bytes, biased toward the sync bytes so false matches get tried
  task automatic send_noise(input int count);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0:       b = ffsd_pkg::HDR_BYTE0;
        1:       b = ffsd_pkg::HDR_BYTE1;
        2:       b = ffsd_pkg::TRL_BYTE0;
        3:       b = ffsd_pkg::TRL_BYTE1;
        default: b = 8'($urandom);
      endcase
      push_byte(b);
    end
  endtask

  // build one frame around the given id at the current offset; fill < 0 means
  // random payload, otherwise every payload byte is the fill value
  task automatic send_frame(input frame_kind_e kind, input logic [ID_W-1:0] id,
                            input int fill);
    logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
    int                sent;
    int                k;
    for (int i = 0; i < FRAME_LEN; i++)
      frame_bytes[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    // id first, sync bytes win where they overlap
    if (int'(cur_offset) < FRAME_LEN) frame_bytes[cur_offset] = id[7:0];
    if (int'(cur_offset) + 1 < FRAME_LEN) frame_bytes[int'(cur_offset) + 1] = id[15:8];
    frame_bytes[0] = ffsd_pkg::HDR_BYTE0;
    frame_bytes[1] = ffsd_pkg::HDR_BYTE1;
    frame_bytes[FRAME_LEN - 2] = ffsd_pkg::TRL_BYTE0;
    frame_bytes[FRAME_LEN - 1] = ffsd_pkg::TRL_BYTE1;
    if (kind == FRAME_BAD_SYNC) begin
      // flip one bit in one of the four sync bytes
      k = $urandom_range(0, 3);
      k = (k < 2) ? k : FRAME_LEN - 4 + k;
      frame_bytes[k] ^= 8'(1 << $urandom_range(0, 7));
    end
    sent = (kind == FRAME_CUT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    for (int i = 0; i < sent; i++) push_byte(frame_bytes[i]);
    id_seq = id;
  endtask

  // wait until every expected word is out and the hunt pipeline is quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_offset(input logic [OFS_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_offset = v;
  endtask

  initial begin
    int pick;
    logic [ID_W-1:0] next_id;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: window filling and sync hunting over edge bytes, reset offset
    foreach (EDGE_BYTES[i]) push_byte(EDGE_BYTES[i]);
    // first frame with id zero, then ids counting up from zero: no gap
    send_frame(FRAME_GOOD, 16'h0000, 8'h00);
    send_frame(FRAME_GOOD, 16'h0001, 8'hFF);
    send_frame(FRAME_GOOD, 16'h0002, -1);
    // forward jump, then a backward jump that wraps the lost count
    send_frame(FRAME_GOOD, 16'h0010, -1);
    send_frame(FRAME_GOOD, 16'h0005, -1);
    // broken sync and a truncated frame, then recovery
    send_frame(FRAME_BAD_SYNC, 16'h0006, -1);
    send_frame(FRAME_CUT, 16'h0006, -1);
    send_frame(FRAME_GOOD, 16'hFFFF, -1);
    // id wraps from all ones to zero: in sequence
    send_frame(FRAME_GOOD, 16'h0000, -1);

    // offset extremes: header bytes, trailer bytes, half and fully past the end
    settle();
    write_offset(OFS_W'(0));
    send_frame(FRAME_GOOD, 16'h1234, -1);
    settle();
    write_offset(OFS_W'(FRAME_LEN - 2));
    send_frame(FRAME_GOOD, 16'h1234, -1);
    settle();
    write_offset(OFS_W'(FRAME_LEN - 1));
    send_frame(FRAME_GOOD, 16'h1234, -1);
    settle();
    write_offset({OFS_W{1'b1}});
    send_frame(FRAME_GOOD, 16'h1234, -1);
    settle();
    write_offset(OFS_W'(1));
    send_frame(FRAME_GOOD, 16'h1234, -1);

    // random phases: mostly well-formed frames with random payload and ids,
    // the rest noise, broken sync and truncated frames
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case ($urandom_range(0, 7))
        0:       write_offset(OFS_W'(0));
        1:       write_offset(OFS_W'(FRAME_LEN - 2));
        2:       write_offset(OFS_W'($urandom_range(FRAME_LEN - 1, (1 << OFS_W) - 1)));
        default: write_offset(OFS_W'($urandom_range(2, FRAME_LEN - 3)));
      endcase
      for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        case ($urandom_range(0, 9))
          0:       next_id = 16'($urandom);
          1:       next_id = '0;
          2:       next_id = '1;
          default: next_id = id_seq + 16'd1;
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 6)
          send_frame(FRAME_GOOD, next_id, -1);
        else if (pick < 8)
          send_noise($urandom_range(1, 20));
        else if (pick == 8)
          send_frame(FRAME_BAD_SYNC, next_id, -1);
        else
          send_frame(FRAME_CUT, next_id, -1);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && words_due == 0) begin
      $display("fixed_frame_sync_deframer regression: pass");
    end else begin
      $display("fixed_frame_sync_deframer regression: fail");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("fixed_frame_sync_deframer regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/core/ffsd_pkg.sv
rtl/core/ffsd_ram.sv
rtl/core/fixed_frame_sync_deframer.sv
dv/ffsd_frame_checker.sv
dv/fixed_frame_sync_deframer_test.sv
